### rtl/core/dds_sine_tone_generator_top_assert.svh
// Assertion macros for the tone generator checker.
// Each expects signals named clk and arst_n in the scope of its use.
`ifndef DDS_SINE_TONE_GENERATOR_TOP_ASSERT_SVH
`define DDS_SINE_TONE_GENERATOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DDS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dds_pkg.sv
`default_nettype none
package dds_pkg;

	localparam int SAMPLE_RATE_HZ = 22050;

	localparam int FREQ_W   = 13;
	localparam int VOL_W    = 14;
	localparam int PHASE_W  = 16;
	localparam int STEP_W   = 15;
	localparam int SAMPLE_W = 15;
	localparam int ROM_AW   = 8;
	localparam int ROM_DW   = 16;
	localparam int KEY_W    = 8;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [KEY_W-1:0] KEY_UP     = 8'h26;
	localparam logic [KEY_W-1:0] KEY_DOWN   = 8'h28;
	localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h27;
	localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h25;
	localparam logic [KEY_W-1:0] KEY_W_CHAR = 8'h77;
	localparam logic [KEY_W-1:0] KEY_S_CHAR = 8'h73;
	localparam logic [KEY_W-1:0] KEY_D_CHAR = 8'h64;
	localparam logic [KEY_W-1:0] KEY_A_CHAR = 8'h61;

	localparam logic [FREQ_W-1:0] FREQ_RESET    = 13'd440;
	localparam logic [FREQ_W-1:0] FREQ_STEP     = 13'd50;
	localparam logic [FREQ_W-1:0] FREQ_MAX      = 13'd8000;
	localparam logic [FREQ_W-1:0] FREQ_MIN      = 13'd50;
	localparam logic [FREQ_W-1:0] FREQ_DOWN_LIM = 13'd100;

	localparam logic [VOL_W-1:0] VOL_RESET    = 14'd2000;
	localparam logic [VOL_W-1:0] VOL_STEP     = 14'd500;
	localparam logic [VOL_W-1:0] VOL_MAX      = 14'd16000;
	localparam logic [VOL_W-1:0] VOL_MIN      = 14'd200;
	localparam logic [VOL_W-1:0] VOL_DOWN_LIM = 14'd700;

	// Phase step = floor(freq * 2^16 / rate) by a ceiling reciprocal; the shift
	// is wide enough that the result is exact for every 13-bit frequency.
	localparam int STEP_SHIFT   = 45;
	localparam int STEP_RECIP_W = 33;
	localparam int STEP_PROD_W  = FREQ_W + STEP_RECIP_W;
	localparam int STEP_Q_LSB   = STEP_SHIFT - PHASE_W;
	localparam int STEP_Q_W     = STEP_PROD_W - STEP_Q_LSB;
	localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = STEP_RECIP_W'(
		((64'd1 << STEP_SHIFT) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ));

	// Volume scaling: floor(mag / 32767) by a ceiling reciprocal, exact below 2^29.
	localparam int MAG_W       = 15;
	localparam int SCALE_W     = MAG_W + VOL_W;
	localparam int VOL_SHIFT   = 44;
	localparam int VOL_RECIP_W = 30;
	localparam int QUO_W       = SCALE_W + VOL_RECIP_W;
	localparam logic [VOL_RECIP_W-1:0] VOL_RECIP = VOL_RECIP_W'(
		((64'd1 << VOL_SHIFT) + 64'd32766) / 64'd32767);

	localparam logic [STEP_W-1:0] STEP_MAX = 15'h7FFF;
	localparam logic [STEP_W-1:0] STEP_MIN = 15'd1;

	function automatic logic [STEP_W-1:0] step_sat(input logic [STEP_Q_W-1:0] q);
		logic [STEP_W-1:0] r;
		if (q == '0) begin
			r = STEP_MIN;
		end else if (q > STEP_Q_W'(STEP_MAX)) begin
			r = STEP_MAX;
		end else begin
			r = q[STEP_W-1:0];
		end
		return r;
	endfunction

	localparam logic [STEP_W-1:0] STEP_RESET =
		step_sat(STEP_Q_W'((int'(FREQ_RESET) * 65536) / SAMPLE_RATE_HZ));

	typedef struct packed {
		logic [VOL_W-1:0]  volume;
		logic [STEP_W-1:0] step;
		logic              busy;
	} tone_t;

	typedef struct packed {
		logic                     valid;
		logic signed [ROM_DW-1:0] raw;
		logic [VOL_W-1:0]         volume;
	} tap_t;

	localparam logic signed [ROM_DW-1:0] SINE_ROM [0:255] = '{
		16'sd0, 16'sd804, 16'sd1608, 16'sd2410, 16'sd3212, 16'sd4011, 16'sd4808, 16'sd5602,
		16'sd6393, 16'sd7179, 16'sd7962, 16'sd8739, 16'sd9512, 16'sd10278, 16'sd11039,
		16'sd11793,
		16'sd12539, 16'sd13279, 16'sd14010, 16'sd14732, 16'sd15446, 16'sd16151, 16'sd16846,
		16'sd17530,
		16'sd18204, 16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787, 16'sd21403, 16'sd22005,
		16'sd22594,
		16'sd23170, 16'sd23731, 16'sd24279, 16'sd24811, 16'sd25330, 16'sd25832, 16'sd26319,
		16'sd26790,
		16'sd27245, 16'sd27683, 16'sd28105, 16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621,
		16'sd29956,
		16'sd30273, 16'sd30571, 16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785,
		16'sd31971,
		16'sd32138, 16'sd32285, 16'sd32412, 16'sd32521, 16'sd32610, 16'sd32679, 16'sd32728,
		16'sd32757,
		16'sd32767, 16'sd32757, 16'sd32728, 16'sd32679, 16'sd32610, 16'sd32521, 16'sd32412,
		16'sd32285,
		16'sd32138, 16'sd31971, 16'sd31785, 16'sd31580, 16'sd31356, 16'sd31113, 16'sd30852,
		16'sd30571,
		16'sd30273, 16'sd29956, 16'sd29621, 16'sd29268, 16'sd28898, 16'sd28510, 16'sd28105,
		16'sd27683,
		16'sd27245, 16'sd26790, 16'sd26319, 16'sd25832, 16'sd25330, 16'sd24811, 16'sd24279,
		16'sd23731,
		16'sd23170, 16'sd22594, 16'sd22005, 16'sd21403, 16'sd20787, 16'sd20159, 16'sd19519,
		16'sd18868,
		16'sd18204, 16'sd17530, 16'sd16846, 16'sd16151, 16'sd15446, 16'sd14732, 16'sd14010,
		16'sd13279,
		16'sd12539, 16'sd11793, 16'sd11039, 16'sd10278, 16'sd9512, 16'sd8739, 16'sd7962,
		16'sd7179,
		16'sd6393, 16'sd5602, 16'sd4808, 16'sd4011, 16'sd3212, 16'sd2410, 16'sd1608, 16'sd804,
		16'sd0, -16'sd804, -16'sd1608, -16'sd2410, -16'sd3212, -16'sd4011, -16'sd4808,
		-16'sd5602,
		-16'sd6393, -16'sd7179, -16'sd7962, -16'sd8739, -16'sd9512, -16'sd10278, -16'sd11039,
		-16'sd11793,
		-16'sd12539, -16'sd13279, -16'sd14010, -16'sd14732, -16'sd15446, -16'sd16151,
		-16'sd16846, -16'sd17530,
		-16'sd18204, -16'sd18868, -16'sd19519, -16'sd20159, -16'sd20787, -16'sd21403,
		-16'sd22005, -16'sd22594,
		-16'sd23170, -16'sd23731, -16'sd24279, -16'sd24811, -16'sd25330, -16'sd25832,
		-16'sd26319, -16'sd26790,
		-16'sd27245, -16'sd27683, -16'sd28105, -16'sd28510, -16'sd28898, -16'sd29268,
		-16'sd29621, -16'sd29956,
		-16'sd30273, -16'sd30571, -16'sd30852, -16'sd31113, -16'sd31356, -16'sd31580,
		-16'sd31785, -16'sd31971,
		-16'sd32138, -16'sd32285, -16'sd32412, -16'sd32521, -16'sd32610, -16'sd32679,
		-16'sd32728, -16'sd32757,
		-16'sd32767, -16'sd32757, -16'sd32728, -16'sd32679, -16'sd32610, -16'sd32521,
		-16'sd32412, -16'sd32285,
		-16'sd32138, -16'sd31971, -16'sd31785, -16'sd31580, -16'sd31356, -16'sd31113,
		-16'sd30852, -16'sd30571,
		-16'sd30273, -16'sd29956, -16'sd29621, -16'sd29268, -16'sd28898, -16'sd28510,
		-16'sd28105, -16'sd27683,
		-16'sd27245, -16'sd26790, -16'sd26319, -16'sd25832, -16'sd25330, -16'sd24811,
		-16'sd24279, -16'sd23731,
		-16'sd23170, -16'sd22594, -16'sd22005, -16'sd21403, -16'sd20787, -16'sd20159,
		-16'sd19519, -16'sd18868,
		-16'sd18204, -16'sd17530, -16'sd16846, -16'sd16151, -16'sd15446, -16'sd14732,
		-16'sd14010, -16'sd13279,
		-16'sd12539, -16'sd11793, -16'sd11039, -16'sd10278, -16'sd9512, -16'sd8739,
		-16'sd7962, -16'sd7179,
		-16'sd6393, -16'sd5602, -16'sd4808, -16'sd4011, -16'sd3212, -16'sd2410, -16'sd1608,
		-16'sd804
	};

endpackage
`default_nettype wire

### rtl/core/dds_if.sv
`default_nettype none
interface dds_cmd_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [dds_pkg::KEY_W-1:0]  key_code;
	logic                       key_pressed;

	modport source(output valid, output opcode, output key_code, output key_pressed,
		input ready);
	modport sink(input valid, input opcode, input key_code, input key_pressed,
		output ready);
endinterface

interface dds_smp_if;
	logic                              valid;
	logic                              ready;
	logic signed [dds_pkg::SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface
`default_nettype wire

### rtl/core/dds_sine_tone_generator_top.sv
// Channel  Dir  Transfer carries
// cmd      in   opcode, key_code, key_pressed (key event or sample tick)
// smp      out  sample (one per sample tick)
//
// Sample ticks are taken one per cycle while cmd.ready is high.
// A key event holds off further items while the phase step
// multiply and saturation update the step register.
// Reset clears the phase and loads 440 Hz, volume 2000 and the matching step.
// A stalled output fills the four pipeline stages before cmd.ready drops.
`default_nettype none
module dds_sine_tone_generator_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dds_cmd_if.sink    cmd,
	dds_smp_if.source  smp
);

	dds_pkg::tone_t tone;
	dds_pkg::tap_t  tap;
	logic           en_s1;
	logic           fire;
	logic           key_fire;
	logic           tick_fire;

	assign cmd.ready = en_s1 & ~tone.busy;
	assign fire      = cmd.valid & cmd.ready;
	assign key_fire  = fire & (cmd.opcode == dds_pkg::OP_KEY);
	assign tick_fire = fire & (cmd.opcode == dds_pkg::OP_TICK);

	dds_key_ctrl u_key (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_fire    (key_fire),
		.key_code    (cmd.key_code),
		.key_pressed (cmd.key_pressed),
		.tone        (tone)
	);

	dds_phase_rom u_rom (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_fire (tick_fire),
		.en_s1     (en_s1),
		.tone      (tone),
		.tap       (tap)
	);

	dds_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.tap        (tap),
		.en_s1      (en_s1),
		.smp_valid  (smp.valid),
		.smp_ready  (smp.ready),
		.smp_sample (smp.sample)
	);

endmodule
`default_nettype wire

### rtl/core/dds_key_ctrl.sv
`default_nettype none
module dds_key_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      key_fire,
	input  wire logic [dds_pkg::KEY_W-1:0] key_code,
	input  wire logic                      key_pressed,
	output dds_pkg::tone_t                 tone
);

	logic [dds_pkg::FREQ_W-1:0]      freq_q;
	logic [dds_pkg::VOL_W-1:0]       vol_q;
	logic [dds_pkg::STEP_W-1:0]      step_q;
	logic                            upd_s1;
	logic                            upd_s2;
	logic [dds_pkg::STEP_PROD_W-1:0] prod_s2;

	logic [dds_pkg::FREQ_W:0]   freq_up;
	logic [dds_pkg::VOL_W:0]    vol_up;
	logic [dds_pkg::FREQ_W-1:0] freq_d;
	logic [dds_pkg::VOL_W-1:0]  vol_d;

	always_comb begin
		freq_up = {1'b0, freq_q} + {1'b0, dds_pkg::FREQ_STEP};
		vol_up  = {1'b0, vol_q} + {1'b0, dds_pkg::VOL_STEP};
		freq_d  = freq_q;
		vol_d   = vol_q;
		if (key_pressed) begin
			case (key_code)
				dds_pkg::KEY_UP, dds_pkg::KEY_W_CHAR: begin
					freq_d = (freq_up > {1'b0, dds_pkg::FREQ_MAX}) ? dds_pkg::FREQ_MAX
						: freq_up[dds_pkg::FREQ_W-1:0];
				end
				dds_pkg::KEY_DOWN, dds_pkg::KEY_S_CHAR: begin
					freq_d = (freq_q >= dds_pkg::FREQ_DOWN_LIM)
						? freq_q - dds_pkg::FREQ_STEP : dds_pkg::FREQ_MIN;
				end
				dds_pkg::KEY_RIGHT, dds_pkg::KEY_D_CHAR: begin
					vol_d = (vol_up > {1'b0, dds_pkg::VOL_MAX}) ? dds_pkg::VOL_MAX
						: vol_up[dds_pkg::VOL_W-1:0];
				end
				dds_pkg::KEY_LEFT, dds_pkg::KEY_A_CHAR: begin
					vol_d = (vol_q >= dds_pkg::VOL_DOWN_LIM)
						? vol_q - dds_pkg::VOL_STEP : dds_pkg::VOL_MIN;
				end
				default: begin
				end
			endcase
		end
	end

	// The step is rebuilt via prod_s2 and upd_s2 after every key event; the top
	// level holds off sample ticks until it has landed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= dds_pkg::FREQ_RESET;
			vol_q  <= dds_pkg::VOL_RESET;
			step_q <= dds_pkg::STEP_RESET;
			upd_s1 <= 1'b0;
			upd_s2 <= 1'b0;
		end else begin
			upd_s1 <= key_fire;
			upd_s2 <= upd_s1;
			if (key_fire) begin
				freq_q <= freq_d;
				vol_q  <= vol_d;
			end
			if (upd_s2) begin
				step_q <= dds_pkg::step_sat(prod_s2[dds_pkg::STEP_PROD_W-1:dds_pkg::STEP_Q_LSB]);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= dds_pkg::STEP_PROD_W'(freq_q) * dds_pkg::STEP_PROD_W'(dds_pkg::STEP_RECIP);
	end

	assign tone.volume = vol_q;
	assign tone.step   = step_q;
	assign tone.busy   = upd_s1 | upd_s2;

endmodule
`default_nettype wire

### rtl/core/dds_phase_rom.sv
`default_nettype none
module dds_phase_rom (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tick_fire,
	input  wire logic           en_s1,
	input  wire dds_pkg::tone_t tone,
	output dds_pkg::tap_t       tap
);

	logic [dds_pkg::PHASE_W-1:0]       phase_q;
	logic                              valid_s1;
	logic signed [dds_pkg::ROM_DW-1:0] raw_s1;
	logic [dds_pkg::VOL_W-1:0]         vol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= tick_fire;
			end
			if (tick_fire) begin
				phase_q <= phase_q + dds_pkg::PHASE_W'(tone.step);
			end
		end
	end

	// Synchronous ROM read, held while the next stage is stalled.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			raw_s1 <= dds_pkg::SINE_ROM[phase_q[dds_pkg::PHASE_W-1 -: dds_pkg::ROM_AW]];
			vol_s1 <= tone.volume;
		end
	end

	assign tap.valid  = valid_s1;
	assign tap.raw    = raw_s1;
	assign tap.volume = vol_s1;

endmodule
`default_nettype wire

### rtl/core/dds_scale.sv
`default_nettype none
module dds_scale (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dds_pkg::tap_t                      tap,
	output logic                                    en_s1,
	output logic                                    smp_valid,
	input  wire logic                               smp_ready,
	output logic signed [dds_pkg::SAMPLE_W-1:0]     smp_sample
);

	logic                              valid_s2;
	logic                              valid_s3;
	logic                              out_valid_q;
	logic [dds_pkg::SCALE_W-1:0]       mag_s2;
	logic                              neg_s2;
	logic [dds_pkg::QUO_W-1:0]         quo_s3;
	logic                              neg_s3;
	logic signed [dds_pkg::SAMPLE_W-1:0] sample_q;

	logic                          en_s2;
	logic                          en_s3;
	logic                          en_out;
	logic [dds_pkg::ROM_DW-1:0]    abs_raw;
	logic [dds_pkg::VOL_W-1:0]     quo;
	logic [dds_pkg::SAMPLE_W-1:0]  quo_ext;

	// Each stage moves on when the one after it is empty or moving.
	assign en_out = ~out_valid_q | smp_ready;
	assign en_s3  = ~valid_s3 | en_out;
	assign en_s2  = ~valid_s2 | en_s3;
	assign en_s1  = ~tap.valid | en_s2;

	assign abs_raw = tap.raw[dds_pkg::ROM_DW-1] ? (~tap.raw + dds_pkg::ROM_DW'(1)) : tap.raw;
	assign quo     = quo_s3[dds_pkg::VOL_SHIFT +: dds_pkg::VOL_W];
	assign quo_ext = {1'b0, quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= tap.valid;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mag_s2 <= dds_pkg::SCALE_W'(abs_raw[dds_pkg::MAG_W-1:0])
				* dds_pkg::SCALE_W'(tap.volume);
			neg_s2 <= tap.raw[dds_pkg::ROM_DW-1];
		end
		if (en_s3) begin
			quo_s3 <= dds_pkg::QUO_W'(mag_s2) * dds_pkg::QUO_W'(dds_pkg::VOL_RECIP);
			neg_s3 <= neg_s2;
		end
		if (en_out) begin
			sample_q <= neg_s3 ? -$signed(quo_ext) : $signed(quo_ext);
		end
	end

	assign smp_valid  = out_valid_q;
	assign smp_sample = sample_q;

endmodule
`default_nettype wire

### rtl/core/dds_chk.sv
`default_nettype none
`include "dds_sine_tone_generator_top_assert.svh"
module dds_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cmd_valid,
	input wire logic                               cmd_ready,
	input wire logic                               cmd_opcode,
	input wire logic                               smp_valid,
	input wire logic                               smp_ready,
	input wire logic signed [dds_pkg::SAMPLE_W-1:0] smp_sample
);

	`DDS_ASSERT_NEXT(a_smp_hold, smp_valid && !smp_ready, smp_valid, "sample dropped while stalled")
	`DDS_ASSERT_NEXT(a_smp_stable, smp_valid && !smp_ready, $stable(smp_sample), "stalled sample changed")
	`DDS_ASSERT_SAME(a_smp_range, smp_valid, (smp_sample >= -15'sd16000) && (smp_sample <= 15'sd16000), "sample out of range")
	`DDS_ASSERT_NEXT(a_key_lock, cmd_valid && cmd_ready && (cmd_opcode == dds_pkg::OP_KEY), !cmd_ready, "item taken during step update")

endmodule

bind dds_sine_tone_generator_top dds_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_opcode (cmd.opcode),
	.smp_valid  (smp.valid),
	.smp_ready  (smp.ready),
	.smp_sample (smp.sample)
);
`default_nettype wire
